/* rtl/pfs_pkg.sv */
package pfs_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int IDX_W       = 4;
    localparam int COL_W       = 15;
    localparam int CH_W        = 5;
    localparam int CHANS       = 3;
    localparam int LEN_W       = 10;
    localparam int MASK_W      = 16;
    localparam int ERR_W       = 8;
    localparam int DELTA_W     = 6;
    localparam int STEP_W      = 8;
    localparam int ACC_W       = 10;
    localparam int ACT_W       = 2;

    localparam logic [CH_W-1:0]   CHAN_MAX = 5'd31;
    localparam logic [LEN_W-1:0]  MAX_FADE = 10'd255;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STEP  = 2'd2;

    typedef struct packed {
        logic                      go;
        logic [CH_W-1:0]           value;
        logic signed [DELTA_W-1:0] delta;
        logic [ERR_W-1:0]          err;
        logic [STEP_W-1:0]         total;
    } t_chan_req;

    typedef struct packed {
        logic              done;
        logic [CH_W-1:0]   value;
        logic [ERR_W-1:0]  err;
    } t_chan_rsp;

endpackage

/* rtl/pfs_chan_unit.sv */
module pfs_chan_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfs_pkg::t_chan_req i_req,
    output pfs_pkg::t_chan_rsp o_rsp
);

    logic                                r_run;
    logic                                r_dir_neg;
    logic [pfs_pkg::CH_W-1:0]            r_val;
    logic signed [pfs_pkg::ACC_W-1:0]    r_err;
    logic [pfs_pkg::DELTA_W-1:0]         neg_delta;
    logic [pfs_pkg::CH_W-1:0]            mag;
    logic                                active;
    logic signed [pfs_pkg::ACC_W-1:0]    err_init;
    logic [pfs_pkg::CH_W-1:0]            n_val;
    logic signed [pfs_pkg::ACC_W-1:0]    n_err;

    always_comb begin
        neg_delta = pfs_pkg::DELTA_W'(0) - i_req.delta;
        mag       = i_req.delta[pfs_pkg::DELTA_W-1] ? neg_delta[pfs_pkg::CH_W-1:0]
                                                    : i_req.delta[pfs_pkg::CH_W-1:0];
        active    = i_req.delta[pfs_pkg::DELTA_W-1] ? (i_req.value != '0)
                                                    : (i_req.value != pfs_pkg::CHAN_MAX);
        err_init  = active ? $signed({2'b00, i_req.err}) - $signed({5'b00000, mag})
                           : $signed({2'b00, i_req.err});
        // one step along the line, clamped at the channel ends
        if (r_dir_neg) begin
            n_val = (r_val == '0) ? r_val : r_val - 5'd1;
        end else begin
            n_val = (r_val == pfs_pkg::CHAN_MAX) ? r_val : r_val + 5'd1;
        end
        n_err = r_err + $signed({2'b00, i_req.total});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_req.go) begin
            r_run     <= 1'b1;
            r_dir_neg <= i_req.delta[pfs_pkg::DELTA_W-1];
            r_val     <= i_req.value;
            r_err     <= err_init;
        end else if (r_run) begin
            if (r_err[pfs_pkg::ACC_W-1]) begin
                r_val <= n_val;
                r_err <= n_err;
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_rsp.done  = r_run && !r_err[pfs_pkg::ACC_W-1];
    assign o_rsp.value = r_val;
    assign o_rsp.err   = r_err[pfs_pkg::ERR_W-1:0];

`ifndef SYNTHESIS
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run && !r_err[pfs_pkg::ACC_W-1] && !i_req.go |=> !r_run)
        else $error("channel unit kept running after error went non-negative");
    a_err_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_err >= -10'sd32)
        else $error("channel error below the largest delta");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.go |-> !r_run)
        else $error("channel unit started while busy");
`endif

endmodule

/* rtl/palette_fade_stepper_unit.sv */
// Palette fade stepper: holds ENTRIES palette entries of 5:5:5 color with a goal
// color each, and fades them with a Bresenham error term per color channel.
// A load word writes one entry if its index is in range, a start word sets deltas
// and errors one entry per cycle, and a final step lands every masked entry on its
// goal and sends the colors. An ordinary step is accepted, passes over each entry
// that is masked off or skipped, runs each channel of each moving entry through the
// single shared channel unit until its error term goes non-negative, and then sends
// the colors; any stall on the output holds the sending of the colors.
// Input stall is high from acceptance until the last result is in the output
// register, and a result waits in that register without blocking the next word.
module palette_fade_stepper_unit #(
    parameter int ENTRIES = pfs_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [pfs_pkg::ACT_W-1:0]    i_action,
    input  logic [pfs_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [pfs_pkg::COL_W-1:0]    i_start_color,
    input  logic [pfs_pkg::COL_W-1:0]    i_goal_color,
    input  logic [pfs_pkg::LEN_W-1:0]    i_fade_length,
    input  logic                         i_skip_first,
    input  logic [pfs_pkg::MASK_W-1:0]   i_entry_mask,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_status,
    output logic [pfs_pkg::IDX_W-1:0]    o_out_index,
    output logic [pfs_pkg::COL_W-1:0]    o_out_color,
    output logic                         o_last
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0]             ENT_LAST = IW'(ENTRIES - 1);
    localparam logic [pfs_pkg::IDX_W:0]   ENT_CNT  = (pfs_pkg::IDX_W + 1)'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_START,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state                              r_state;
    logic [IW-1:0]                       r_ent;
    logic [1:0]                          r_ch;
    logic [ENTRIES-1:0]                  r_mask;
    logic                                r_skip;
    logic [pfs_pkg::ERR_W-1:0]           r_half;
    logic [pfs_pkg::STEP_W-1:0]          r_steps_left;
    logic [pfs_pkg::STEP_W-1:0]          r_steps_total;
    logic                                r_one_status;
    logic [pfs_pkg::IDX_W-1:0]           r_one_idx;
    logic [pfs_pkg::COL_W-1:0]           r_one_col;
    logic                                r_out_valid;
    logic                                r_out_status;
    logic [pfs_pkg::IDX_W-1:0]           r_out_index;
    logic [pfs_pkg::COL_W-1:0]           r_out_color;
    logic                                r_out_last;

    logic [pfs_pkg::COL_W-1:0]                  r_cur   [ENTRIES];
    logic [pfs_pkg::COL_W-1:0]                  r_goal  [ENTRIES];
    logic [pfs_pkg::CHANS*pfs_pkg::DELTA_W-1:0] r_delta [ENTRIES];
    logic [pfs_pkg::CHANS*pfs_pkg::ERR_W-1:0]   r_errs  [ENTRIES];

    logic                                       out_free;
    logic                                       idx_ok;
    logic                                       eligible;
    logic [pfs_pkg::COL_W-1:0]                  ent_color;
    logic [pfs_pkg::CHANS*pfs_pkg::DELTA_W-1:0] ent_delta;
    pfs_pkg::t_chan_req                         chan_req;
    pfs_pkg::t_chan_rsp                         chan_rsp;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign idx_ok    = ({1'b0, i_entry_index} < ENT_CNT);
    assign eligible  = r_mask[r_ent] && !(r_skip && (r_ent == '0));
    assign ent_color = r_cur[r_ent];

    always_comb begin
        for (int c = 0; c < pfs_pkg::CHANS; c++) begin
            ent_delta[c*pfs_pkg::DELTA_W +: pfs_pkg::DELTA_W] =
                pfs_pkg::DELTA_W'({1'b0, r_goal[r_ent][c*pfs_pkg::CH_W +: pfs_pkg::CH_W]})
              - pfs_pkg::DELTA_W'({1'b0, r_cur[r_ent][c*pfs_pkg::CH_W +: pfs_pkg::CH_W]});
        end
    end

    always_comb begin
        chan_req.go    = (r_state == S_ISSUE) && eligible;
        chan_req.value = r_cur[r_ent][r_ch*pfs_pkg::CH_W +: pfs_pkg::CH_W];
        chan_req.delta = r_delta[r_ent][r_ch*pfs_pkg::DELTA_W +: pfs_pkg::DELTA_W];
        chan_req.err   = r_errs[r_ent][r_ch*pfs_pkg::ERR_W +: pfs_pkg::ERR_W];
        chan_req.total = r_steps_total;
    end

    pfs_chan_unit u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (chan_req),
        .o_rsp   (chan_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_steps_left  <= '0;
            r_steps_total <= 8'd1;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_ONE) && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ent  <= '0;
                        r_ch   <= '0;
                        r_mask <= i_entry_mask[ENTRIES-1:0];
                        r_skip <= i_skip_first;
                        unique case (i_action)
                            pfs_pkg::ACT_LOAD: begin
                                r_one_idx <= i_entry_index;
                                r_state   <= S_ONE;
                                if (idx_ok) begin
                                    r_cur[i_entry_index[IW-1:0]]  <= i_start_color;
                                    r_goal[i_entry_index[IW-1:0]] <= i_goal_color;
                                    r_one_status <= 1'b0;
                                    r_one_col    <= i_start_color;
                                end else begin
                                    r_one_status <= 1'b1;
                                    r_one_col    <= '0;
                                end
                            end
                            pfs_pkg::ACT_START: begin
                                r_one_idx <= '0;
                                r_one_col <= '0;
                                if (i_fade_length <= pfs_pkg::MAX_FADE) begin
                                    r_half        <= pfs_pkg::ERR_W'(i_fade_length >> 1);
                                    r_steps_total <= (i_fade_length == '0) ? 8'd1
                                                     : i_fade_length[pfs_pkg::STEP_W-1:0];
                                    r_steps_left  <= (i_fade_length == '0) ? 8'd1
                                                     : i_fade_length[pfs_pkg::STEP_W-1:0];
                                    r_one_status  <= 1'b0;
                                    r_state       <= S_START;
                                end else begin
                                    r_one_status  <= 1'b1;
                                    r_state       <= S_ONE;
                                end
                            end
                            pfs_pkg::ACT_STEP: begin
                                r_one_status <= 1'b1;
                                r_one_idx    <= '0;
                                r_one_col    <= '0;
                                if (r_steps_left == 8'd1) begin
                                    // final step lands every masked entry on its goal
                                    for (int e = 0; e < ENTRIES; e++) begin
                                        if (i_entry_mask[e]) begin
                                            r_cur[e] <= r_goal[e];
                                        end
                                    end
                                    r_steps_left <= '0;
                                    r_state      <= S_EMIT;
                                end else if (r_steps_left != '0) begin
                                    r_state <= S_ISSUE;
                                end else begin
                                    r_state <= S_ONE;
                                end
                            end
                            default: begin
                                r_one_status <= 1'b1;
                                r_one_idx    <= '0;
                                r_one_col    <= '0;
                                r_state      <= S_ONE;
                            end
                        endcase
                    end
                end
                S_ONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_one_status;
                        r_out_index  <= r_one_idx;
                        r_out_color  <= r_one_col;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_START: begin
                    r_delta[r_ent] <= ent_delta;
                    r_errs[r_ent]  <= {pfs_pkg::CHANS{r_half}};
                    if (r_ent == ENT_LAST) begin
                        r_state <= S_ONE;
                    end else begin
                        r_ent <= r_ent + 1'b1;
                    end
                end
                S_ISSUE: begin
                    if (eligible) begin
                        r_state <= S_WAIT;
                    end else if (r_ent == ENT_LAST) begin
                        r_steps_left <= r_steps_left - 8'd1;
                        r_ent        <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_ent <= r_ent + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (chan_rsp.done) begin
                        r_cur[r_ent][r_ch*pfs_pkg::CH_W +: pfs_pkg::CH_W]   <= chan_rsp.value;
                        r_errs[r_ent][r_ch*pfs_pkg::ERR_W +: pfs_pkg::ERR_W] <= chan_rsp.err;
                        if (r_ch == 2'd2) begin
                            r_ch <= '0;
                            if (r_ent == ENT_LAST) begin
                                r_steps_left <= r_steps_left - 8'd1;
                                r_ent        <= '0;
                                r_state      <= S_EMIT;
                            end else begin
                                r_ent   <= r_ent + 1'b1;
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= 1'b0;
                        r_out_index  <= pfs_pkg::IDX_W'(r_ent);
                        r_out_color  <= ent_color;
                        r_out_last   <= (r_ent == ENT_LAST);
                        if (r_ent == ENT_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ent <= r_ent + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_index = r_out_index;
    assign o_out_color = r_out_color;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps_total != '0)
        else $error("fade length register is zero");
    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps_left <= r_steps_total)
        else $error("steps left exceeds fade length");
    a_multi_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> !r_out_status)
        else $error("multi-word result carries a reject status");
`endif

endmodule
